>>> rtl/bbpc_pkg.sv
package bbpc_pkg;

   localparam int unsigned TimeWidth = 32;
   localparam int unsigned CountWidth = 32;
   localparam int unsigned CsrIndexWidth = 3;

   localparam logic [TimeWidth-1:0] MinDebounce = 32'd50;

   // register indexes on the configuration port
   localparam logic [CsrIndexWidth-1:0] CSR_DEBOUNCE_TIME = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_INVERT_LEVEL = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_MIN_ACTIVE_TIME = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_MAX_ACTIVE_TIME = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_MIN_IDLE_TIME = 3'd4;

   // request modes
   localparam logic [1:0] MODE_SAMPLE = 2'd0;
   localparam logic [1:0] MODE_RESET_COUNTS = 2'd1;
   localparam logic [1:0] MODE_CLEAR_JAM = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0] mode;
      logic pin_level;
      logic [TimeWidth-1:0] now_time;
   } req_payload_type;

   typedef struct packed {
      logic [CountWidth-1:0] part_count;
      logic [CountWidth-1:0] glitch_count;
      logic blocked;
      logic jam_flag;
   } rsp_payload_type;

   typedef struct packed {
      logic [TimeWidth-1:0] debounce_time;
      logic invert_level;
      logic [TimeWidth-1:0] min_active_time;
      logic [TimeWidth-1:0] max_active_time;
      logic [TimeWidth-1:0] min_idle_time;
   } cfg_type;

   typedef struct packed {
      logic raw_level_candidate;
      logic [TimeWidth-1:0] raw_change_time;
      logic stable_broken;
      logic [TimeWidth-1:0] stable_change_time;
      logic armed_flag;
      logic counted_in_break;
      logic jam_state;
      logic [CountWidth-1:0] part_counter;
      logic [CountWidth-1:0] glitch_counter;
   } state_type;

   localparam state_type StateReset = '{
      raw_level_candidate: 1'b0,
      raw_change_time: '0,
      stable_broken: 1'b0,
      stable_change_time: '0,
      armed_flag: 1'b1,
      counted_in_break: 1'b0,
      jam_state: 1'b0,
      part_counter: '0,
      glitch_counter: '0
   };

endpackage

>>> rtl/bbpc_csr.sv
module bbpc_csr (
   input  logic clock,
   input  logic reset,
   input  logic csr_valid,
   input  logic [bbpc_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [bbpc_pkg::TimeWidth-1:0] csr_data,
   output bbpc_pkg::cfg_type cfg
);

   bbpc_pkg::cfg_type cfg_ff;
   bbpc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            bbpc_pkg::CSR_DEBOUNCE_TIME: begin
               // clamp to the minimum debounce
               cfg_in.debounce_time = (csr_data < bbpc_pkg::MinDebounce) ?
                                      bbpc_pkg::MinDebounce : csr_data;
            end
            bbpc_pkg::CSR_INVERT_LEVEL: cfg_in.invert_level = csr_data[0];
            bbpc_pkg::CSR_MIN_ACTIVE_TIME: cfg_in.min_active_time = csr_data;
            bbpc_pkg::CSR_MAX_ACTIVE_TIME: cfg_in.max_active_time = csr_data;
            bbpc_pkg::CSR_MIN_IDLE_TIME: cfg_in.min_idle_time = csr_data;
            default: ; // drop writes to unknown indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time <= bbpc_pkg::MinDebounce;
         cfg_ff.invert_level <= 1'b0;
         cfg_ff.min_active_time <= '0;
         cfg_ff.max_active_time <= '0;
         cfg_ff.min_idle_time <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/bbpc_step.sv
module bbpc_step (
   input  bbpc_pkg::cfg_type cfg,
   input  bbpc_pkg::req_payload_type req,
   input  bbpc_pkg::state_type state,
   output bbpc_pkg::state_type state_next
);

   logic broken;
   logic cand_change;
   logic settled;
   logic flip;
   logic [bbpc_pkg::TimeWidth-1:0] raw_age;
   logic [bbpc_pkg::TimeWidth-1:0] stable_age;
   logic [bbpc_pkg::TimeWidth-1:0] held;

   assign broken = cfg.invert_level ? ~req.pin_level : req.pin_level;
   assign cand_change = broken != state.raw_level_candidate;
   assign raw_age = req.now_time - state.raw_change_time;
   // a fresh candidate has age zero, below the minimum debounce
   assign settled = !cand_change && (raw_age >= cfg.debounce_time);
   assign flip = settled && (broken != state.stable_broken);
   assign stable_age = req.now_time - state.stable_change_time;
   assign held = flip ? '0 : stable_age;

   always_comb begin
      state_next = state;
      unique case (req.mode)
         bbpc_pkg::MODE_SAMPLE: begin
            if (cand_change) begin
               state_next.raw_level_candidate = broken;
               state_next.raw_change_time = req.now_time;
            end
            if (flip) begin
               state_next.stable_broken = broken;
               state_next.counted_in_break = 1'b0;
               state_next.stable_change_time = req.now_time;
               if (!broken) begin
                  if (!state.counted_in_break) begin
                     state_next.glitch_counter = state.glitch_counter + 1'b1;
                  end
                  state_next.armed_flag = 1'b0;
                  state_next.jam_state = 1'b0;
               end
            end
            if (state_next.stable_broken) begin
               if ((cfg.max_active_time != '0) && (held >= cfg.max_active_time)) begin
                  state_next.jam_state = 1'b1;
               end
               if (state_next.armed_flag && !state_next.counted_in_break &&
                   (held >= cfg.min_active_time)) begin
                  state_next.part_counter = state.part_counter + 1'b1;
                  state_next.counted_in_break = 1'b1;
                  state_next.armed_flag = 1'b0;
               end
            end else if (!state_next.armed_flag && (held >= cfg.min_idle_time)) begin
               state_next.armed_flag = 1'b1;
            end
         end
         bbpc_pkg::MODE_RESET_COUNTS: begin
            state_next.part_counter = '0;
            state_next.glitch_counter = '0;
            state_next.counted_in_break = 1'b0;
            state_next.jam_state = 1'b0;
            state_next.armed_flag = 1'b1;
         end
         bbpc_pkg::MODE_CLEAR_JAM: state_next.jam_state = 1'b0;
         bbpc_pkg::MODE_UNUSED: ; // report status only
         default: ;
      endcase
   end

endmodule

>>> rtl/break_beam_part_counter_top.sv
// Path: a request passes the input register, then the result register, before
//    rsp_valid rises; the response comes later while rsp_ready holds low.
// Throughput: one request per cycle, unless rsp_ready holds low while both stages
//    are full; the debounce and timing update for an item is one pass of
//    subtract/compare logic between the two registers.
// Reset: synchronous, active high; clears both stages, restores the tracker
//    state (armed, counters zero) and the configuration defaults.
module break_beam_part_counter_top (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  bbpc_pkg::req_payload_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output bbpc_pkg::rsp_payload_type rsp_data,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [bbpc_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [bbpc_pkg::TimeWidth-1:0] csr_data
);

   bbpc_pkg::cfg_type cfg;

   // input stage
   logic s1_valid_ff;
   logic s1_valid_in;
   bbpc_pkg::req_payload_type s1_data_ff;

   // tracker state, updated as an item leaves the input stage
   bbpc_pkg::state_type state_ff;
   bbpc_pkg::state_type state_in;

   // result stage
   logic out_valid_ff;
   logic out_valid_in;
   bbpc_pkg::rsp_payload_type out_data_ff;
   bbpc_pkg::rsp_payload_type out_data_in;

   logic req_xfer;
   logic advance;

   // Configuration writes are always taken; the register file settles
   // clamping and unknown indexes.
   assign csr_ready = 1'b1;

   bbpc_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .cfg(cfg)
   );

   bbpc_step u_step (
      .cfg(cfg),
      .req(s1_data_ff),
      .state(state_ff),
      .state_next(state_in)
   );

   // Advance the input stage whenever the result register is free or its
   // transfer completes this cycle; the result register is the skid point.
   assign advance = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_xfer = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // The response reports status after this item's update.
   always_comb begin
      out_data_in.part_count = state_in.part_counter;
      out_data_in.glitch_count = state_in.glitch_counter;
      out_data_in.blocked = state_in.stable_broken;
      out_data_in.jam_flag = state_in.jam_state;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff <= bbpc_pkg::StateReset;
      end else begin
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers: hold unless loaded
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_data_ff;

endmodule

>>> rtl/bbpc_checker.sv
module bbpc_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  bbpc_pkg::rsp_payload_type rsp_data
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // jam can only be reported while the beam is broken
   a_jam_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.jam_flag |-> rsp_data.blocked)
      else $error("jam flag without blocked beam");

   // an empty result register always leaves room for a request
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty result register");

   // a request taken last cycle fills the input stage; with the result stalled, stall input
   a_full_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && $past(req_valid && req_ready) |-> !req_ready)
      else $error("request taken with both stages full");

   // no response right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind break_beam_part_counter_top bbpc_checker u_bbpc_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data(rsp_data)
);
